FILE: sv/ils_pkg.sv
// Package for the indexed list store: sizes, request and status codes,
// controller states and the structs passed between modules. No dependencies.
package ils_pkg;

  localparam int DEPTH      = 64;
  localparam int WORD_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int FUNC_W   = 3;
  localparam int POS_W    = 7;
  localparam int IWORD_W  = 32;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int FPOS_W   = 6;
  localparam int COUNT_W  = 7;

  localparam logic [FUNC_W-1:0] FN_APPEND    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ      = 3'd3;
  localparam logic [FUNC_W-1:0] FN_OVERWRITE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_FIND      = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd6;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_UP_LAST,
    ST_FINAL_WR,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [WORD_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
    logic                found;
    logic [FPOS_W-1:0]   found_position;
    logic [COUNT_W-1:0]  count;
    logic                empty_res;
  } res_t;

endpackage

FILE: sv/ils_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on ils_pkg for field widths.
interface ils_in_if import ils_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [POS_W-1:0]   position;
  logic [IWORD_W-1:0] word;

  modport source (output valid, func, position, word, input ready);
  modport sink (input valid, func, position, word, output ready);
endinterface

interface ils_out_if import ils_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   data;
  logic                found;
  logic [FPOS_W-1:0]   found_position;
  logic [COUNT_W-1:0]  count;
  logic                empty_res;

  modport source (output valid, status, data, found, found_position, count, empty_res,
                  input ready);
  modport sink (input valid, status, data, found, found_position, count, empty_res,
                output ready);
endinterface

FILE: sv/ils_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ils_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ils_ctrl.sv
// Request sequencer of the indexed list store: takes request items, walks
// the element memory for shifts and searches, and builds the result.
// Depends on ils_pkg and ils_in_if.
module ils_ctrl import ils_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ils_in_if.sink                in_ch,
  output mem_req_t              mem_req,
  input  logic [WORD_WIDTH-1:0] mem_rdata,
  output logic                  res_valid,
  output res_t                  res,
  input  logic                  res_ready
);

  ctrl_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ADDR_W-1:0]     ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]     last_rd_r, last_rd_nxt;
  logic [ADDR_W-1:0]     end_r, end_nxt;
  logic                  pend_r, pend_nxt;
  logic [FUNC_W-1:0]     op_r, op_nxt;
  logic [ADDR_W-1:0]     pos_r, pos_nxt;
  logic [WORD_WIDTH-1:0] word_r, word_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [WORD_WIDTH-1:0] data_r, data_nxt;
  logic                  found_r, found_nxt;
  logic [ADDR_W-1:0]     fpos_r, fpos_nxt;
  logic                  in_acc;
  logic                  full;
  logic [ADDR_W-1:0]     last_idx;

  assign in_ch.ready = rst_n && (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(DEPTH));
  assign last_idx    = ADDR_W'(count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    last_rd_r <= last_rd_nxt;
    end_r     <= end_nxt;
    op_r      <= op_nxt;
    pos_r     <= pos_nxt;
    word_r    <= word_nxt;
    status_r  <= status_nxt;
    data_r    <= data_nxt;
    found_r   <= found_nxt;
    fpos_r    <= fpos_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    last_rd_nxt = last_rd_r;
    end_nxt     = end_r;
    pend_nxt    = pend_r;
    op_nxt      = op_r;
    pos_nxt     = pos_r;
    word_nxt    = word_r;
    status_nxt  = status_r;
    data_nxt    = data_r;
    found_nxt   = found_r;
    fpos_nxt    = fpos_r;
    mem_req     = '{we: 1'b0, waddr: '0, wdata: '0, raddr: ptr_r};
    res_valid   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_ch.func;
          pos_nxt    = in_ch.position[ADDR_W-1:0];
          word_nxt   = in_ch.word[WORD_WIDTH-1:0];
          status_nxt = STAT_OK;
          data_nxt   = '0;
          found_nxt  = 1'b0;
          fpos_nxt   = '0;
          pend_nxt   = 1'b0;
          state_nxt  = ST_DONE;
          unique case (in_ch.func)
            FN_APPEND: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = count_r[ADDR_W-1:0];
                mem_req.wdata = in_ch.word[WORD_WIDTH-1:0];
                count_nxt     = count_r + CNT_W'(1);
              end
            end
            FN_INSERT: begin
              if (in_ch.position > POS_W'(count_r)) begin
                status_nxt = STAT_RANGE;
              end else if (full) begin
                status_nxt = STAT_FULL;
              end else if (in_ch.position == POS_W'(count_r)) begin
                state_nxt = ST_FINAL_WR;
              end else begin
                ptr_nxt   = last_idx;
                state_nxt = ST_SHIFT_UP;
              end
            end
            FN_REMOVE, FN_READ: begin
              if (in_ch.position >= POS_W'(count_r)) begin
                status_nxt = STAT_RANGE;
              end else begin
                ptr_nxt   = in_ch.position[ADDR_W-1:0];
                end_nxt   = (in_ch.func == FN_REMOVE) ? last_idx
                                                      : in_ch.position[ADDR_W-1:0];
                state_nxt = ST_SCAN;
              end
            end
            FN_OVERWRITE: begin
              if (in_ch.position >= POS_W'(count_r)) begin
                status_nxt = STAT_RANGE;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = in_ch.position[ADDR_W-1:0];
                mem_req.wdata = in_ch.word[WORD_WIDTH-1:0];
              end
            end
            FN_FIND: begin
              if (count_r != '0) begin
                ptr_nxt   = '0;
                end_nxt   = last_idx;
                state_nxt = ST_SCAN;
              end
            end
            FN_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SHIFT_UP, ST_UP_LAST: begin
        mem_req.we    = pend_r;
        mem_req.waddr = last_rd_r + ADDR_W'(1);
        mem_req.wdata = mem_rdata;
        if (state_r == ST_SHIFT_UP) begin
          last_rd_nxt = ptr_r;
          pend_nxt    = 1'b1;
          if (ptr_r == pos_r) begin
            state_nxt = ST_UP_LAST;
          end else begin
            ptr_nxt = ptr_r - ADDR_W'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_FINAL_WR;
        end
      end

      ST_FINAL_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        mem_req.wdata = word_r;
        count_nxt     = count_r + CNT_W'(1);
        state_nxt     = ST_DONE;
      end

      ST_SCAN, ST_SCAN_LAST: begin
        if (pend_r) begin
          priority if (op_r == FN_FIND) begin
            if (!found_r && (mem_rdata == word_r)) begin
              found_nxt = 1'b1;
              fpos_nxt  = last_rd_r;
            end
          end else if (op_r == FN_READ || last_rd_r == pos_r) begin
            data_nxt = mem_rdata;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = last_rd_r - ADDR_W'(1);
            mem_req.wdata = mem_rdata;
          end
        end
        if (state_r == ST_SCAN) begin
          last_rd_nxt = ptr_r;
          pend_nxt    = 1'b1;
          if (ptr_r == end_r) begin
            state_nxt = ST_SCAN_LAST;
          end else begin
            ptr_nxt = ptr_r + ADDR_W'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
          if (op_r == FN_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res.status         = status_r;
  assign res.data           = DATA_W'(data_r);
  assign res.found          = found_r;
  assign res.found_position = FPOS_W'(fpos_r);
  assign res.count          = COUNT_W'(count_r);
  assign res.empty_res      = (count_r == '0);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (CNT_W'(mem_req.waddr) <= count_r))
    else $error("write beyond end of list");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == FN_APPEND && !full) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("append did not add an element");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == FN_CLEAR) |=> (count_r == '0 && state_r == ST_DONE))
    else $error("clear left elements behind");
`endif

endmodule

FILE: sv/ils_out_reg.sv
// Result output register: holds one result item until the sink takes it.
// Depends on ils_pkg and ils_out_if.
module ils_out_reg import ils_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_valid,
  input  res_t       res,
  output logic       res_ready,
  ils_out_if.source  out_ch
);

  logic valid_r;
  res_t res_r;

  assign res_ready = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.status         = res_r.status;
  assign out_ch.data           = res_r.data;
  assign out_ch.found          = res_r.found;
  assign out_ch.found_position = res_r.found_position;
  assign out_ch.count          = res_r.count;
  assign out_ch.empty_res      = res_r.empty_res;

endmodule

FILE: sv/indexed_list_store.sv
// Indexed list store: an ordered list of up to 64 words of 32 bits held in one
// synchronous element memory, with append, insert, remove, read, overwrite,
// find and clear requests, one result item per request. Requests are taken one
// at a time. Insert shifts the elements at and after the position up, remove
// shifts those after the position down, read fetches one element and find
// scans the list; each step goes through the single read port of the element
// memory, which moves or compares one element per cycle. A finished result
// waits in an output register, so the next request is taken while it is still
// pending. Depends on ils_pkg, ils_if, ils_ram, ils_ctrl and ils_out_reg.
module indexed_list_store import ils_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ils_in_if.sink    in_ch,
  ils_out_if.source out_ch
);

  mem_req_t              mem_req;
  logic [WORD_WIDTH-1:0] mem_rdata;
  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;

  ils_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (WORD_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  ils_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/tb_indexed_list_store.sv
// Self-checking testbench for indexed_list_store: a directed table followed by
// random phased traffic, each result checked against the table's expected result
// or a shadow list in the bench. Depends on ils_pkg, ils_if and the indexed_list_store RTL.
`timescale 1ns / 100ps

module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int RAND_ITEMS  = 1350;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;

  typedef enum {PH_GROW, PH_SHRINK, PH_MIXED, PH_DUPS} phase_t;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   pos;
    logic [IWORD_W-1:0] word;
    bit                 typed;
    res_t               want;
  } req_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   calm = 1'b0;
  int   err_count = 0;

  logic [WORD_WIDTH-1:0] shadow_words [DEPTH];
  int                    shadow_len;
  res_t                  pending_results [$];
  req_row_t              dir_rows [$];

  ils_in_if  in_ch ();
  ils_out_if out_ch ();

  indexed_list_store DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
  end

  function automatic res_t mk_res(logic [STATUS_W-1:0] s, logic [DATA_W-1:0] d,
                                  logic [COUNT_W-1:0] c);
    res_t r;
    r = '0;
    r.status    = s;
    r.data      = d;
    r.count     = c;
    r.empty_res = (c == 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic res_t apply_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                                         logic [IWORD_W-1:0] w);
    res_t r;
    int   pi;
    int   i;
    bit   hit;
    r   = '0;
    pi  = int'(p);
    hit = 1'b0;
    case (f)
      FN_APPEND: begin
        if (shadow_len >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_words[shadow_len] = w;
          shadow_len++;
        end
      end
      FN_INSERT: begin
        if (pi > shadow_len) begin
          r.status = STAT_RANGE;
        end else if (shadow_len >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          for (i = shadow_len; i > pi; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pi] = w;
          shadow_len++;
        end
      end
      FN_REMOVE: begin
        if (pi >= shadow_len) begin
          r.status = STAT_RANGE;
        end else begin
          r.data = shadow_words[pi];
          for (i = pi; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      FN_READ: begin
        if (pi >= shadow_len) r.status = STAT_RANGE;
        else r.data = shadow_words[pi];
      end
      FN_OVERWRITE: begin
        if (pi >= shadow_len) r.status = STAT_RANGE;
        else shadow_words[pi] = w;
      end
      FN_FIND: begin
        for (i = 0; i < shadow_len; i++) begin
          if (!hit && shadow_words[i] == w) begin
            hit = 1'b1;
            r.found = 1'b1;
            r.found_position = i[FPOS_W-1:0];
          end
        end
      end
      FN_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.count     = shadow_len[COUNT_W-1:0];
    r.empty_res = (shadow_len == 0);
    return r;
  endfunction

  task automatic pick_request(input phase_t kind, output logic [FUNC_W-1:0] f,
                              output logic [POS_W-1:0] p, output logic [IWORD_W-1:0] w);
    int r;
    int wr;
    bit bad;
    r   = $urandom_range(0, 99);
    bad = ($urandom_range(0, 9) == 0);
    case (kind)
      PH_GROW: begin
        if (r < 45) f = FN_APPEND;
        else if (r < 75) f = FN_INSERT;
        else if (r < 83) f = FN_FIND;
        else if (r < 91) f = FN_READ;
        else if (r < 97) f = FN_OVERWRITE;
        else f = FN_REMOVE;
      end
      PH_SHRINK: begin
        if (r < 50) f = FN_REMOVE;
        else if (r < 65) f = FN_READ;
        else if (r < 80) f = FN_FIND;
        else if (r < 90) f = FN_OVERWRITE;
        else if (r < 95) f = FN_APPEND;
        else if (r < 99) f = FN_INSERT;
        else f = FN_CLEAR;
      end
      default: begin
        f = FUNC_W'($urandom_range(FN_APPEND, FN_CLEAR));
        if (f == FN_CLEAR && $urandom_range(0, 9) != 0) f = FN_READ;
      end
    endcase
    if (f == FN_INSERT) begin
      if (bad && shadow_len < DEPTH) p = POS_W'($urandom_range(shadow_len + 1, DEPTH));
      else p = POS_W'($urandom_range(0, shadow_len));
    end else begin
      if (bad || shadow_len == 0) p = POS_W'($urandom_range(shadow_len, DEPTH));
      else p = POS_W'($urandom_range(0, shadow_len - 1));
    end
    wr = $urandom_range(0, 9);
    if (kind == PH_DUPS) w = IWORD_W'($urandom_range(0, 3));
    else if (wr < 3 && shadow_len > 0) w = shadow_words[$urandom_range(0, shadow_len - 1)];
    else if (wr == 3) w = '0;
    else if (wr == 4) w = '1;
    else w = $urandom;
  endtask

  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                              input logic [IWORD_W-1:0] w, input bit typed, input res_t want);
    res_t r;
    int   gap;
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.position <= p;
    in_ch.word     <= w;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = apply_request(f, p, w);
    pending_results.push_back(typed ? want : r);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got.status         = out_ch.status;
    got.data           = out_ch.data;
    got.found          = out_ch.found;
    got.found_position = out_ch.found_position;
    got.count          = out_ch.count;
    got.empty_res      = out_ch.empty_res;
    if (pending_results.size() == 0) begin
      $error("result item arrived with none expected");
      err_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        err_count++;
      end
      if (got.data !== want.data) begin
        $error("data: expected %h, got %h", want.data, got.data);
        err_count++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        err_count++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0d, got %0d", want.found_position,
               got.found_position);
        err_count++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        err_count++;
      end
      if (got.empty_res !== want.empty_res) begin
        $error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
        err_count++;
      end
    end
  endtask

  initial begin
    int hold_left;
    int stall_left;
    int seen;
    bit pressed;
    hold_left  = 0;
    stall_left = 0;
    seen       = 0;
    pressed    = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        check_result();
        seen++;
      end
      // hold off once for a long stretch so the request side backs up
      if (!pressed && seen == 300) begin
        pressed   = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int                 n;
    int                 phase_left;
    phase_t             kind;
    logic [FUNC_W-1:0]  f;
    logic [POS_W-1:0]   p;
    logic [IWORD_W-1:0] w;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= FN_APPEND;
    in_ch.position <= '0;
    in_ch.word     <= '0;
    shadow_len = 0;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    dir_rows = '{
      '{FN_READ,      7'd0,  32'h0000_0000, 1'b1, mk_res(STAT_RANGE, 32'h0, 7'd0)},
      '{FN_REMOVE,    7'd0,  32'h0000_0000, 1'b1, mk_res(STAT_RANGE, 32'h0, 7'd0)},
      '{FN_FIND,      7'd0,  32'h0000_0000, 1'b1, mk_res(STAT_OK,    32'h0, 7'd0)},
      '{FN_INSERT,    7'd1,  32'hFFFF_FFFF, 1'b1, mk_res(STAT_RANGE, 32'h0, 7'd0)},
      '{FN_OVERWRITE, 7'd0,  32'hFFFF_FFFF, 1'b1, mk_res(STAT_RANGE, 32'h0, 7'd0)},
      '{FN_CLEAR,     7'd0,  32'h0000_0000, 1'b1, mk_res(STAT_OK,    32'h0, 7'd0)},
      '{FN_INSERT,    7'd0,  32'hFFFF_FFFF, 1'b1, mk_res(STAT_OK,    32'h0, 7'd1)},
      '{FN_APPEND,    7'd0,  32'h0000_0000, 1'b1, mk_res(STAT_OK,    32'h0, 7'd2)},
      '{FN_APPEND,    7'd0,  32'hA5A5_A5A5, 1'b1, mk_res(STAT_OK,    32'h0, 7'd3)},
      '{FN_INSERT,    7'd1,  32'h5A5A_5A5A, 1'b0, res_t'('0)},
      '{FN_INSERT,    7'd4,  32'h0000_0001, 1'b0, res_t'('0)},
      '{FN_READ,      7'd0,  32'h0000_0000, 1'b0, res_t'('0)},
      '{FN_READ,      7'd4,  32'h0000_0000, 1'b0, res_t'('0)},
      '{FN_FIND,      7'd0,  32'h0000_0000, 1'b0, res_t'('0)},
      '{FN_FIND,      7'd0,  32'h0000_0001, 1'b0, res_t'('0)},
      '{FN_FIND,      7'd0,  32'hDEAD_BEEF, 1'b0, res_t'('0)},
      '{FN_OVERWRITE, 7'd0,  32'h1234_5678, 1'b0, res_t'('0)},
      '{FN_OVERWRITE, 7'd5,  32'h0000_0000, 1'b1, mk_res(STAT_RANGE, 32'h0, 7'd5)},
      '{FN_INSERT,    7'd64, 32'h0000_0000, 1'b1, mk_res(STAT_RANGE, 32'h0, 7'd5)},
      '{FN_REMOVE,    7'd64, 32'h0000_0000, 1'b1, mk_res(STAT_RANGE, 32'h0, 7'd5)},
      '{FN_REMOVE,    7'd0,  32'h0000_0000, 1'b0, res_t'('0)},
      '{FN_REMOVE,    7'd3,  32'h0000_0000, 1'b0, res_t'('0)},
      '{FN_READ,      7'd0,  32'h0000_0000, 1'b0, res_t'('0)},
      '{FN_CLEAR,     7'd0,  32'h0000_0000, 1'b1, mk_res(STAT_OK,    32'h0, 7'd0)},
      '{FN_APPEND,    7'd0,  32'hFFFF_FFFF, 1'b1, mk_res(STAT_OK,    32'h0, 7'd1)}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i])
      send_request(dir_rows[i].func, dir_rows[i].pos, dir_rows[i].word,
                   dir_rows[i].typed, dir_rows[i].want);
    phase_left = 0;
    kind       = PH_GROW;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (phase_left == 0) begin
        kind       = phase_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      pick_request(kind, f, p, w);
      send_request(f, p, w, 1'b0, res_t'('0));
    end
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: indexed_list_store.f
sv/ils_pkg.sv
sv/ils_if.sv
sv/ils_ram.sv
sv/ils_ctrl.sv
sv/ils_out_reg.sv
sv/indexed_list_store.sv
tb/tb_indexed_list_store.sv
